// ===== hdl/fys_pkg.sv =====
// Shared types and constants of the Fisher-Yates shuffle block.
package fys_pkg;

    localparam int MAX_DEPTH = 64;
    localparam int ADDR_W    = 6;
    localparam int CNT_W     = 7;

    localparam logic [63:0] GEN_SEED = 64'h2cf9_1502_1e83_12a0;
    localparam logic [63:0] GEN_MULT = 64'h2545_f491_4f6c_dd1d;
    localparam int          GEN_SH_A = 12;
    localparam int          GEN_SH_B = 25;
    localparam int          GEN_SH_C = 27;

    typedef struct packed {
        logic [7:0] element;
        logic       final_item;
    } t_in_item;

    typedef struct packed {
        logic [7:0] shuffled_element;
        logic       end_of_run;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_STORE,
        OP_STORE_LAST,
        OP_CLOSE
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  count;
        logic [7:0]        element;
    } t_cmd;

endpackage

// ===== hdl/fisher_yates_shuffle_xorshift.sv =====
// Top level of the Fisher-Yates shuffle block with an xorshift64* generator.
// Items are loaded through a two-entry command queue, one per cycle while it is not
// full, into a store of DEPTH entries; the item flagged final closes the set, items
// past DEPTH are dropped. The engine then shuffles the n loaded elements in place:
// each of the n-1 positions takes one generator step, four passes through a shared
// 32x32 multiplier (three partial products of the 64-bit xorshift* product and the
// range scaling) and a read-read-write-write swap on the store, which has one read
// and one write port. The permuted elements then leave one at a time, each read
// from the store and then pushed, the last one flagged end_of_run, through a
// two-entry result queue; readout waits while that queue is full.
// New items are accepted into the command queue while the engine works, until it
// is full. The generator state persists across sets.
module fisher_yates_shuffle_xorshift import fys_pkg::*; #(
    parameter int DEPTH         = 64,
    parameter int ELEMENT_WIDTH = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_in_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_out_item
);
    localparam int CMD_W = $bits(t_cmd);
    localparam int OUT_W = $bits(t_out_item);

    logic      cq_push;
    logic      cq_full;
    logic      cq_pop;
    logic      cq_empty;
    t_cmd      cq_in;
    t_cmd      cq_out;
    logic      oq_push;
    logic      oq_full;
    t_out_item oq_in;

    fys_front #(
        .DEPTH(DEPTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (i_in_item),
        .o_full   (full),
        .i_q_full (cq_full),
        .o_q_push (cq_push),
        .o_q_cmd  (cq_in)
    );

    fys_fifo #(
        .WIDTH     (CMD_W),
        .ADDR_BITS (1)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cq_push),
        .i_data  (cq_in),
        .o_full  (cq_full),
        .i_pop   (cq_pop),
        .o_data  (cq_out),
        .o_empty (cq_empty)
    );

    fys_engine #(
        .DEPTH         (DEPTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cq_out),
        .i_cmd_empty (cq_empty),
        .o_cmd_pop   (cq_pop),
        .i_out_full  (oq_full),
        .o_out_push  (oq_push),
        .o_out_item  (oq_in)
    );

    fys_fifo #(
        .WIDTH     (OUT_W),
        .ADDR_BITS (1)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (oq_push),
        .i_data  (oq_in),
        .o_full  (oq_full),
        .i_pop   (pop),
        .o_data  (o_out_item),
        .o_empty (empty)
    );

endmodule

// ===== hdl/fys_fifo.sv =====
// Small first-in first-out queue of register entries.
module fys_fifo #(
    parameter int WIDTH     = 9,
    parameter int ADDR_BITS = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int ENTRIES = 2 ** ADDR_BITS;

    logic [WIDTH-1:0]     r_mem [ENTRIES];
    logic [ADDR_BITS-1:0] r_wp;
    logic [ADDR_BITS-1:0] r_rp;
    logic [ADDR_BITS:0]   r_cnt;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = (r_cnt == (ADDR_BITS + 1)'(ENTRIES));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== hdl/fys_front.sv =====
// Input side: assigns store slots and turns each item into a command.
module fys_front import fys_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    output logic     o_full,
    input  logic     i_q_full,
    output logic     o_q_push,
    output t_cmd     o_q_cmd
);
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          accept;
    logic          has_room;

    assign o_full   = i_q_full;
    assign accept   = i_push && !i_q_full;
    assign has_room = (r_count < CW'(DEPTH));

    always_comb begin
        o_q_push        = 1'b0;
        o_q_cmd.op      = OP_STORE;
        o_q_cmd.addr    = ADDR_W'(r_count);
        o_q_cmd.count   = CNT_W'(r_count + 1'b1);
        o_q_cmd.element = i_item.element;
        n_count         = r_count;
        if (accept) begin
            if (has_room) begin
                o_q_push   = 1'b1;
                o_q_cmd.op = i_item.final_item ? OP_STORE_LAST : OP_STORE;
                n_count    = r_count + 1'b1;
            end else if (i_item.final_item) begin
                o_q_push      = 1'b1;
                o_q_cmd.op    = OP_CLOSE;
                o_q_cmd.count = CNT_W'(DEPTH);
            end
            if (i_item.final_item) begin
                n_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

// ===== hdl/fys_engine.sv =====
// Back side: element store, xorshift64* generator, in-place shuffle and readout.
module fys_engine import fys_pkg::*; #(
    parameter int DEPTH         = 64,
    parameter int ELEMENT_WIDTH = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  logic      i_cmd_empty,
    output logic      o_cmd_pop,
    input  logic      i_out_full,
    output logic      o_out_push,
    output t_out_item o_out_item
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = ELEMENT_WIDTH;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GEN,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_SCALE,
        S_RDJ,
        S_SWAP1,
        S_SWAP2,
        S_ERD,
        S_EPUSH
    } t_state;

    function automatic logic [63:0] xorshift(input logic [63:0] s);
        logic [63:0] t;
        t = s ^ (s >> GEN_SH_A);
        t = t ^ (t << GEN_SH_B);
        t = t ^ (t >> GEN_SH_C);
        return t;
    endfunction

    logic [EW-1:0] r_mem [DEPTH];
    logic [EW-1:0] r_rdata;
    logic [EW-1:0] r_vi;
    t_state        r_state;
    logic [63:0]   r_gen;
    logic [31:0]   r_acc;
    logic [AW-1:0] r_i;
    logic [AW-1:0] r_j;
    logic [AW-1:0] r_k;
    logic [CW-1:0] r_n;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [31:0]   mul_a;
    logic [31:0]   mul_b;
    logic [63:0]   mul_p;
    logic [CW-1:0] span;
    logic [CW-1:0] j_raw;
    logic [CW-1:0] j_sel;
    logic [CW-1:0] i_next;
    logic          last_out;

    assign o_cmd_pop  = (r_state == S_IDLE) && !i_cmd_empty;
    assign span       = r_n - CW'(r_i);
    assign mul_p      = {32'b0, mul_a} * {32'b0, mul_b};
    assign j_raw      = CW'(r_i) + CW'(mul_p[63:32]);
    assign j_sel      = (j_raw >= r_n) ? (r_n - 1'b1) : j_raw;
    assign i_next     = CW'(r_i) + 1'b1;
    assign last_out   = ((CW'(r_k) + 1'b1) == r_n);
    assign o_out_push = (r_state == S_EPUSH);
    assign o_out_item.shuffled_element = 8'(r_rdata);
    assign o_out_item.end_of_run       = last_out;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_i;
        mem_wdata = r_rdata;
        mem_raddr = r_i;
        mul_a     = r_gen[31:0];
        mul_b     = GEN_MULT[31:0];
        unique case (r_state)
            S_IDLE: begin
                mem_we    = o_cmd_pop && (i_cmd.op != OP_CLOSE);
                mem_waddr = AW'(i_cmd.addr);
                mem_wdata = EW'(i_cmd.element);
            end
            S_MUL1: begin
                mul_b = GEN_MULT[63:32];
            end
            S_MUL2: begin
                mul_a = r_gen[63:32];
            end
            S_SCALE: begin
                mul_a = r_acc;
                mul_b = 32'(span);
            end
            S_RDJ: begin
                mem_raddr = r_j;
            end
            S_SWAP1: begin
                mem_we = 1'b1;
            end
            S_SWAP2: begin
                mem_we    = 1'b1;
                mem_waddr = r_j;
                mem_wdata = r_vi;
            end
            S_ERD: begin
                mem_raddr = r_k;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_gen   <= GEN_SEED;
            r_i     <= '0;
            r_k     <= '0;
            r_n     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop && (i_cmd.op != OP_STORE)) begin
                        r_n <= CW'(i_cmd.count);
                        r_i <= '0;
                        r_k <= '0;
                        r_state <= (i_cmd.count > CNT_W'(1)) ? S_GEN : S_ERD;
                    end
                end
                S_GEN: begin
                    r_gen   <= xorshift(r_gen);
                    r_state <= S_MUL0;
                end
                S_MUL0: begin
                    r_vi    <= r_rdata;
                    r_acc   <= mul_p[63:32];
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_acc   <= r_acc + mul_p[31:0];
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_acc   <= r_acc + mul_p[31:0];
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_j     <= AW'(j_sel);
                    r_state <= S_RDJ;
                end
                S_RDJ: begin
                    r_state <= S_SWAP1;
                end
                S_SWAP1: begin
                    r_state <= S_SWAP2;
                end
                S_SWAP2: begin
                    if ((i_next + 1'b1) < r_n) begin
                        r_i     <= AW'(i_next);
                        r_state <= S_GEN;
                    end else begin
                        r_k     <= '0;
                        r_state <= S_ERD;
                    end
                end
                S_ERD: begin
                    if (!i_out_full) begin
                        r_state <= S_EPUSH;
                    end
                end
                S_EPUSH: begin
                    if (last_out) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_ERD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sim/fisher_yates_shuffle_xorshift_tb.sv =====
// Self-checking testbench of the Fisher-Yates shuffle block, directed sets then random sets.
module fisher_yates_shuffle_xorshift_tb;
    import fys_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = MAX_DEPTH;
    localparam int RANDOM_ITEMS = 260;
    localparam int STALL_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 40;

    typedef struct {
        logic [7:0] element;
        logic       final_item;
        bit         typed;
        logic [7:0] exp_element;
    } t_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      push;
    logic      full;
    t_in_item  i_in_item;
    logic      empty;
    logic      pop;
    t_out_item o_out_item;

    logic [7:0]  shuffle_store [DEPTH];
    int          held_count;
    logic [63:0] rng_state;
    t_out_item   shuffled_q [$];

    int fail_count;
    int stall_cycles;
    int send_idle;
    int recv_idle;

    fisher_yates_shuffle_xorshift #(
        .DEPTH        (DEPTH),
        .ELEMENT_WIDTH(8)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_in_item (i_in_item),
        .empty     (empty),
        .pop       (pop),
        .o_out_item(o_out_item)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [31:0] advance_rng();
        logic [63:0] s;
        logic [63:0] p;
        s = rng_state;
        s ^= s >> GEN_SH_A;
        s ^= s << GEN_SH_B;
        s ^= s >> GEN_SH_C;
        rng_state = s;
        p = s * GEN_MULT;
        return p[63:32];
    endfunction

    function automatic void load_element(input t_in_item it, input bit emit);
        int          n;
        int          i;
        int          j;
        int          k;
        logic [7:0]  t;
        logic [63:0] scaled;
        t_out_item   r;
        if (held_count < DEPTH) begin
            shuffle_store[held_count] = it.element;
            held_count++;
        end
        if (!it.final_item) return;
        n = held_count;
        for (i = 0; i + 1 < n; i++) begin
            scaled = {32'b0, advance_rng()} * 64'(n - i);
            j = i + int'(scaled[63:32]);
            if (j >= n) j = n - 1;
            t = shuffle_store[i];
            shuffle_store[i] = shuffle_store[j];
            shuffle_store[j] = t;
        end
        if (emit) begin
            for (k = 0; k < n; k++) begin
                r.shuffled_element = shuffle_store[k];
                r.end_of_run       = (k == n - 1);
                shuffled_q.push_back(r);
            end
        end
        held_count = 0;
    endfunction

    task automatic send_item(input t_in_item it, input bit typed = 1'b0,
                             input logic [7:0] typed_element = 8'h00);
        t_out_item r;
        while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push      <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        load_element(it, !typed);
        if (typed) begin
            r.shuffled_element = typed_element;
            r.end_of_run       = 1'b1;
            shuffled_q.push_back(r);
        end
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        pop <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && pop && !empty) begin
            if (shuffled_q.size() == 0) begin
                $error("item with no expectation: shuffled_element %0h end_of_run %0b",
                       o_out_item.shuffled_element, o_out_item.end_of_run);
                fail_count++;
            end else begin
                want = shuffled_q.pop_front();
                if (o_out_item.shuffled_element !== want.shuffled_element) begin
                    $error("shuffled_element: expected %0h, got %0h",
                           want.shuffled_element, o_out_item.shuffled_element);
                    fail_count++;
                end
                if (o_out_item.end_of_run !== want.end_of_run) begin
                    $error("end_of_run: expected %0b, got %0b",
                           want.end_of_run, o_out_item.end_of_run);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("** fisher_yates_shuffle_xorshift: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        t_row     rows [$];
        t_in_item it;
        int       sent;
        int       set_no;
        int       set_size;
        int       e;
        i_rst_n      = 1'b0;
        push         = 1'b0;
        pop          = 1'b0;
        i_in_item    = '0;
        fail_count   = 0;
        stall_cycles = 0;
        send_idle    = 27;
        recv_idle    = 78;
        held_count   = 0;
        rng_state    = GEN_SEED;
        foreach (shuffle_store[a]) shuffle_store[a] = 8'h00;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Single elements come back unchanged with end_of_run set; other sets are shuffled.
        rows = '{
            '{8'hFF, 1'b1, 1'b1, 8'hFF},
            '{8'h00, 1'b1, 1'b1, 8'h00},
            '{8'h00, 1'b0, 1'b0, 8'h00},
            '{8'hFF, 1'b1, 1'b0, 8'h00},
            '{8'h55, 1'b0, 1'b0, 8'h00},
            '{8'hAA, 1'b0, 1'b0, 8'h00},
            '{8'h01, 1'b1, 1'b0, 8'h00},
            '{8'h80, 1'b1, 1'b1, 8'h80},
            '{8'h10, 1'b0, 1'b0, 8'h00},
            '{8'h11, 1'b0, 1'b0, 8'h00},
            '{8'h12, 1'b0, 1'b0, 8'h00},
            '{8'h13, 1'b0, 1'b0, 8'h00},
            '{8'h14, 1'b0, 1'b0, 8'h00},
            '{8'h15, 1'b0, 1'b0, 8'h00},
            '{8'h16, 1'b0, 1'b0, 8'h00},
            '{8'h17, 1'b1, 1'b0, 8'h00},
            '{8'h7F, 1'b0, 1'b0, 8'h00},
            '{8'hFE, 1'b0, 1'b0, 8'h00},
            '{8'h02, 1'b0, 1'b0, 8'h00},
            '{8'hFD, 1'b0, 1'b0, 8'h00},
            '{8'h40, 1'b0, 1'b0, 8'h00},
            '{8'hBF, 1'b1, 1'b0, 8'h00},
            '{8'h3C, 1'b1, 1'b1, 8'h3C}
        };
        foreach (rows[r]) begin
            it.element    = rows[r].element;
            it.final_item = rows[r].final_item;
            send_item(it, rows[r].typed, rows[r].exp_element);
        end

        // A full store, then a set whose 3 items past DEPTH are dropped, then random sets.
        sent   = 0;
        set_no = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= 2 * RANDOM_ITEMS / 3) begin
                send_idle = 0;
                recv_idle = 0;
            end else if (sent >= RANDOM_ITEMS / 3) begin
                send_idle = 78;
                recv_idle = 27;
            end
            if (set_no == 0)
                set_size = DEPTH;
            else if (set_no == 1)
                set_size = DEPTH + 3;
            else if ($urandom_range(11) == 0)
                set_size = $urandom_range(DEPTH, 13);
            else
                set_size = $urandom_range(12, 1);
            for (e = 0; e < set_size; e++) begin
                it.element    = $urandom_range(255);
                it.final_item = (e == set_size - 1);
                send_item(it);
                sent++;
            end
            set_no++;
        end
        push <= 1'b0;

        while (shuffled_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("** fisher_yates_shuffle_xorshift: PASSED **");
        end else begin
            $display("** fisher_yates_shuffle_xorshift: FAILED **");
        end
        $finish;
    end

endmodule
